>>> hw/rtl/rvalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rvalu_pkg;

    localparam int XLEN     = 32;
    localparam int IDXW     = 5;
    localparam int IMMW     = 12;
    localparam int CMDW     = 5;
    localparam int QDEPTH   = 2;
    localparam int S_DATAW  = 32;
    localparam int M_DATAW  = 40;

    // Operation codes as they arrive on the input stream.
    localparam logic [CMDW-1:0] CMD_ADDI  = 5'd0;
    localparam logic [CMDW-1:0] CMD_SLTI  = 5'd1;
    localparam logic [CMDW-1:0] CMD_SLTIU = 5'd2;
    localparam logic [CMDW-1:0] CMD_XORI  = 5'd3;
    localparam logic [CMDW-1:0] CMD_ORI   = 5'd4;
    localparam logic [CMDW-1:0] CMD_ANDI  = 5'd5;
    localparam logic [CMDW-1:0] CMD_SLLI  = 5'd6;
    localparam logic [CMDW-1:0] CMD_SRLI  = 5'd7;
    localparam logic [CMDW-1:0] CMD_SRAI  = 5'd8;
    localparam logic [CMDW-1:0] CMD_ADD   = 5'd9;
    localparam logic [CMDW-1:0] CMD_SUB   = 5'd10;
    localparam logic [CMDW-1:0] CMD_SLL   = 5'd11;
    localparam logic [CMDW-1:0] CMD_SLT   = 5'd12;
    localparam logic [CMDW-1:0] CMD_SLTU  = 5'd13;
    localparam logic [CMDW-1:0] CMD_XOR   = 5'd14;
    localparam logic [CMDW-1:0] CMD_SRL   = 5'd15;
    localparam logic [CMDW-1:0] CMD_SRA   = 5'd16;
    localparam logic [CMDW-1:0] CMD_OR    = 5'd17;
    localparam logic [CMDW-1:0] CMD_AND   = 5'd18;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_OR,
        ALU_AND,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_NONE
    } t_alu;

    typedef struct packed {
        t_alu                   alu;
        logic                   use_imm;
        logic                   wr_en;
        logic                   rs1_zero;
        logic                   rs2_zero;
        logic [IDXW-1:0]        rd;
        logic [IDXW-1:0]        rs1;
        logic [IDXW-1:0]        rs2;
        logic signed [IMMW-1:0] imm;
    } t_op;

endpackage

`default_nettype wire

>>> hw/rtl/rvalu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rvalu_front #(
    parameter int REG_COUNT = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [rvalu_pkg::CMDW-1:0]       i_command,
    input  wire logic [rvalu_pkg::IDXW-1:0]       i_dest_index,
    input  wire logic [rvalu_pkg::IDXW-1:0]       i_first_source_index,
    input  wire logic [rvalu_pkg::IDXW-1:0]       i_second_source_index,
    input  wire logic signed [rvalu_pkg::IMMW-1:0] i_immediate_value,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output rvalu_pkg::t_op                        o_op
);

    localparam logic [rvalu_pkg::IDXW:0] REG_LIMIT = (rvalu_pkg::IDXW + 1)'(REG_COUNT);

    logic           r_valid;
    rvalu_pkg::t_op r_op;
    rvalu_pkg::t_op n_op;

    // A register number beyond the file reads as zero, like x0.
    function automatic logic idx_absent(input logic [rvalu_pkg::IDXW-1:0] idx);
        idx_absent = (idx == '0) || ({1'b0, idx} >= REG_LIMIT);
    endfunction

    always_comb begin
        n_op          = '0;
        n_op.rd       = i_dest_index;
        n_op.rs1      = i_first_source_index;
        n_op.rs2      = i_second_source_index;
        n_op.imm      = i_immediate_value;
        n_op.rs1_zero = idx_absent(i_first_source_index);
        n_op.rs2_zero = idx_absent(i_second_source_index);
        n_op.use_imm  = 1'b0;
        n_op.alu      = rvalu_pkg::ALU_NONE;
        unique case (i_command)
            rvalu_pkg::CMD_ADDI:  begin n_op.alu = rvalu_pkg::ALU_ADD;  n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_SLTI:  begin n_op.alu = rvalu_pkg::ALU_SLT;  n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_SLTIU: begin n_op.alu = rvalu_pkg::ALU_SLTU; n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_XORI:  begin n_op.alu = rvalu_pkg::ALU_XOR;  n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_ORI:   begin n_op.alu = rvalu_pkg::ALU_OR;   n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_ANDI:  begin n_op.alu = rvalu_pkg::ALU_AND;  n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_SLLI:  begin n_op.alu = rvalu_pkg::ALU_SLL;  n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_SRLI:  begin n_op.alu = rvalu_pkg::ALU_SRL;  n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_SRAI:  begin n_op.alu = rvalu_pkg::ALU_SRA;  n_op.use_imm = 1'b1; end
            rvalu_pkg::CMD_ADD:   n_op.alu = rvalu_pkg::ALU_ADD;
            rvalu_pkg::CMD_SUB:   n_op.alu = rvalu_pkg::ALU_SUB;
            rvalu_pkg::CMD_SLL:   n_op.alu = rvalu_pkg::ALU_SLL;
            rvalu_pkg::CMD_SLT:   n_op.alu = rvalu_pkg::ALU_SLT;
            rvalu_pkg::CMD_SLTU:  n_op.alu = rvalu_pkg::ALU_SLTU;
            rvalu_pkg::CMD_XOR:   n_op.alu = rvalu_pkg::ALU_XOR;
            rvalu_pkg::CMD_SRL:   n_op.alu = rvalu_pkg::ALU_SRL;
            rvalu_pkg::CMD_SRA:   n_op.alu = rvalu_pkg::ALU_SRA;
            rvalu_pkg::CMD_OR:    n_op.alu = rvalu_pkg::ALU_OR;
            rvalu_pkg::CMD_AND:   n_op.alu = rvalu_pkg::ALU_AND;
            default:              n_op.alu = rvalu_pkg::ALU_NONE;
        endcase
        // Unknown commands and writes to x0 or beyond the file leave the file alone.
        n_op.wr_en = (n_op.alu != rvalu_pkg::ALU_NONE) && !idx_absent(i_dest_index);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_op <= n_op;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rvalu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rvalu_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire rvalu_pkg::t_op i_op,
    output logic                o_valid,
    input  wire logic           i_ready,
    output rvalu_pkg::t_op      o_op
);

    localparam int PTRW = $clog2(rvalu_pkg::QDEPTH);
    localparam int CNTW = $clog2(rvalu_pkg::QDEPTH + 1);
    localparam logic [CNTW-1:0] FULL = CNTW'(rvalu_pkg::QDEPTH);
    localparam logic [PTRW-1:0] LAST = PTRW'(rvalu_pkg::QDEPTH - 1);

    rvalu_pkg::t_op  r_mem [rvalu_pkg::QDEPTH];
    logic [PTRW-1:0] r_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rvalu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rvalu_back #(
    parameter int REG_COUNT = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire rvalu_pkg::t_op              i_op,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rvalu_pkg::IDXW-1:0]       o_written_index,
    output logic [rvalu_pkg::XLEN-1:0]       o_written_value
);

    localparam int AW = $clog2(REG_COUNT);
    localparam int SHW = $clog2(rvalu_pkg::XLEN);

    logic [rvalu_pkg::XLEN-1:0] r_rf [REG_COUNT];
    logic [REG_COUNT-1:0]       r_rf_vld;

    // Execute stage.
    logic                       r_e_valid;
    rvalu_pkg::t_op             r_e_op;
    logic [rvalu_pkg::XLEN-1:0] r_a_mem;
    logic [rvalu_pkg::XLEN-1:0] r_b_mem;
    logic                       r_a_vld;
    logic                       r_b_vld;
    logic                       r_fa;
    logic                       r_fb;
    logic [rvalu_pkg::XLEN-1:0] r_fwd_val;

    // Output register.
    logic                       r_out_valid;
    logic [rvalu_pkg::IDXW-1:0] r_out_idx;
    logic [rvalu_pkg::XLEN-1:0] r_out_val;

    logic                       e_fire;
    logic                       adv;
    logic [rvalu_pkg::XLEN-1:0] op_a;
    logic [rvalu_pkg::XLEN-1:0] op_b;
    logic [rvalu_pkg::XLEN-1:0] rs2_val;
    logic [SHW-1:0]             shamt;
    logic [rvalu_pkg::XLEN-1:0] n_alu;
    logic [rvalu_pkg::XLEN-1:0] n_res;
    logic [AW-1:0]              ra;
    logic [AW-1:0]              rb;
    logic [AW-1:0]              wa;

    assign e_fire  = r_e_valid && (!r_out_valid || i_ready);
    assign adv     = !r_e_valid || e_fire;
    assign o_ready = adv;

    assign ra = i_op.rs1[AW-1:0];
    assign rb = i_op.rs2[AW-1:0];
    assign wa = r_e_op.rd[AW-1:0];

    // The register read is taken on the edge where the item ahead writes, so a
    // source that matches that write takes the forwarded result instead.
    always_comb begin
        if (r_e_op.rs1_zero) begin
            op_a = '0;
        end else if (r_fa) begin
            op_a = r_fwd_val;
        end else begin
            op_a = r_a_vld ? r_a_mem : '0;
        end
        if (r_e_op.rs2_zero) begin
            rs2_val = '0;
        end else if (r_fb) begin
            rs2_val = r_fwd_val;
        end else begin
            rs2_val = r_b_vld ? r_b_mem : '0;
        end
        op_b  = r_e_op.use_imm ? rvalu_pkg::XLEN'(r_e_op.imm) : rs2_val;
        shamt = op_b[SHW-1:0];
    end

    always_comb begin
        unique case (r_e_op.alu)
            rvalu_pkg::ALU_ADD:  n_alu = op_a + op_b;
            rvalu_pkg::ALU_SUB:  n_alu = op_a - op_b;
            rvalu_pkg::ALU_SLT:  n_alu = rvalu_pkg::XLEN'($signed(op_a) < $signed(op_b));
            rvalu_pkg::ALU_SLTU: n_alu = rvalu_pkg::XLEN'(op_a < op_b);
            rvalu_pkg::ALU_XOR:  n_alu = op_a ^ op_b;
            rvalu_pkg::ALU_OR:   n_alu = op_a | op_b;
            rvalu_pkg::ALU_AND:  n_alu = op_a & op_b;
            rvalu_pkg::ALU_SLL:  n_alu = op_a << shamt;
            rvalu_pkg::ALU_SRL:  n_alu = op_a >> shamt;
            rvalu_pkg::ALU_SRA:  n_alu = rvalu_pkg::XLEN'($signed(op_a) >>> shamt);
            default:             n_alu = '0;
        endcase
        n_res = r_e_op.wr_en ? n_alu : '0;
    end

    // Register file storage: written by the execute stage, read at two addresses.
    always_ff @(posedge i_clk) begin
        if (e_fire && r_e_op.wr_en) begin
            r_rf[wa] <= n_res;
        end
        if (adv) begin
            r_a_mem <= r_rf[ra];
            r_b_mem <= r_rf[rb];
        end
    end

    // Entries that were never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (e_fire && r_e_op.wr_en) begin
            r_rf_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fa        <= 1'b0;
            r_fb        <= 1'b0;
        end else begin
            if (adv) begin
                r_e_valid <= i_valid;
                r_fa      <= e_fire && r_e_op.wr_en && (r_e_op.rd == i_op.rs1);
                r_fb      <= e_fire && r_e_op.wr_en && (r_e_op.rd == i_op.rs2);
            end
            if (e_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (adv) begin
            r_e_op    <= i_op;
            r_a_vld   <= r_rf_vld[ra];
            r_b_vld   <= r_rf_vld[rb];
            r_fwd_val <= n_res;
        end
        if (e_fire) begin
            r_out_idx <= r_e_op.rd;
            r_out_val <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_written_index = r_out_idx;
    assign o_written_value = r_out_val;

endmodule

`default_nettype wire

>>> hw/rtl/rv32i_integer_alu_execute_top.sv
// RV32I integer ALU execute block with a private register file.
//
// Input stream (s_axis): one decoded ALU instruction per item. tdata holds
// command, destination, first and second source numbers and the 12-bit
// immediate. Output stream (m_axis): one item per instruction with the
// register number written and the value written (zero for x0, for a
// destination beyond the file and for an unknown command).
//
// Throughput is one item per clock while m_axis is not stalled. From input
// acceptance to o_m_axis_tvalid an item passes the decode register, which
// takes it on the accepting edge, the queue, the execute stage (loaded
// together with the registered register file read port) and the ALU, which
// writes the file and the output register on the same edge. A result written by
// one item is forwarded to the next item's operands.
//
// Reset clears all control state and marks every register as zero. A stall
// on m_axis holds the output register; the stages behind it keep filling, the
// two-entry queue absorbs the front, and o_s_axis_tready drops only when the
// whole path is full.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_integer_alu_execute_top #(
    parameter int REG_COUNT = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [4:0] command, [9:5] dest_index, [14:10] first_source_index,
    // [19:15] second_source_index, [31:20] immediate_value
    input  wire logic [31:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [4:0] written_index, [36:5] written_value, [39:37] zero
    output logic [39:0]      o_m_axis_tdata
);

    logic                          fq_valid;
    logic                          fq_ready;
    rvalu_pkg::t_op                fq_op;
    logic                          qb_valid;
    logic                          qb_ready;
    rvalu_pkg::t_op                qb_op;
    logic [rvalu_pkg::IDXW-1:0]    written_index;
    logic [rvalu_pkg::XLEN-1:0]    written_value;

    rvalu_front #(
        .REG_COUNT(REG_COUNT)
    ) u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_s_axis_tvalid),
        .o_ready               (o_s_axis_tready),
        .i_command             (i_s_axis_tdata[4:0]),
        .i_dest_index          (i_s_axis_tdata[9:5]),
        .i_first_source_index  (i_s_axis_tdata[14:10]),
        .i_second_source_index (i_s_axis_tdata[19:15]),
        .i_immediate_value     ($signed(i_s_axis_tdata[31:20])),
        .o_valid               (fq_valid),
        .i_ready               (fq_ready),
        .o_op                  (fq_op)
    );

    rvalu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_op    (fq_op),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_op    (qb_op)
    );

    rvalu_back #(
        .REG_COUNT(REG_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (qb_valid),
        .o_ready         (qb_ready),
        .i_op            (qb_op),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_written_index (written_index),
        .o_written_value (written_value)
    );

    assign o_m_axis_tdata = {3'b000, written_value, written_index};

endmodule

`default_nettype wire

>>> hw/rtl/rvalu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rvalu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [31:0] i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata
);

    // A stalled result must stay offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output item withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    // x0 is never written, so its reported value is always zero.
    a_x0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[4:0] == 5'd0) |-> (o_m_axis_tdata[36:5] == 32'd0))
        else $error("nonzero value reported for x0");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind rv32i_integer_alu_execute_top rvalu_checker u_rvalu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 60;
    localparam int PER_PHASE    = 560;
    localparam int N_DIRECTED   = 25;

    // Command codes that decode to no operation.
    localparam logic [rvalu_pkg::CMDW-1:0] CMD_FIRST_UNKNOWN = 5'd19;
    localparam logic [rvalu_pkg::CMDW-1:0] CMD_TOP_CODE      = 5'd31;

    typedef struct packed {
        logic [rvalu_pkg::IDXW-1:0] idx;
        logic [rvalu_pkg::XLEN-1:0] val;
    } t_reg_write;

    typedef struct packed {
        logic [rvalu_pkg::CMDW-1:0] cmd;
        logic [rvalu_pkg::IDXW-1:0] rd;
        logic [rvalu_pkg::IDXW-1:0] rs1;
        logic [rvalu_pkg::IDXW-1:0] rs2;
        logic [rvalu_pkg::IMMW-1:0] imm;
        logic                       fixed;
        logic [rvalu_pkg::XLEN-1:0] want;
    } t_stim_row;

    // Registers start at zero, so x1 = 2047 and x2 = -2048 after the first two rows.
    localparam t_stim_row DIRECTED [0:N_DIRECTED-1] = '{
        '{rvalu_pkg::CMD_ADDI,  5'd1,  5'd0,  5'd0,  12'h7FF, 1'b1, 32'h0000_07FF},
        '{rvalu_pkg::CMD_ADDI,  5'd2,  5'd0,  5'd0,  12'h800, 1'b1, 32'hFFFF_F800},
        '{rvalu_pkg::CMD_ADDI,  5'd0,  5'd1,  5'd0,  12'h005, 1'b1, 32'h0000_0000},
        '{rvalu_pkg::CMD_ADD,   5'd31, 5'd1,  5'd2,  12'h000, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SUB,   5'd3,  5'd2,  5'd1,  12'h000, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SLTI,  5'd4,  5'd2,  5'd0,  12'h000, 1'b1, 32'h0000_0001},
        '{rvalu_pkg::CMD_SLTIU, 5'd5,  5'd1,  5'd0,  12'hFFF, 1'b1, 32'h0000_0001},
        '{rvalu_pkg::CMD_XORI,  5'd6,  5'd2,  5'd0,  12'hFFF, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_ORI,   5'd7,  5'd1,  5'd0,  12'h800, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_ANDI,  5'd8,  5'd2,  5'd0,  12'h7FF, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SLLI,  5'd9,  5'd1,  5'd0,  12'h01F, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SLLI,  5'd10, 5'd1,  5'd0,  12'h020, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SRLI,  5'd11, 5'd2,  5'd0,  12'h004, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SRAI,  5'd12, 5'd2,  5'd0,  12'h03F, 1'b1, 32'hFFFF_FFFF},
        '{rvalu_pkg::CMD_SLL,   5'd13, 5'd2,  5'd1,  12'h000, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SLT,   5'd14, 5'd2,  5'd1,  12'h000, 1'b1, 32'h0000_0001},
        '{rvalu_pkg::CMD_SLTU,  5'd15, 5'd2,  5'd1,  12'h000, 1'b1, 32'h0000_0000},
        '{rvalu_pkg::CMD_XOR,   5'd16, 5'd31, 5'd1,  12'h000, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SRL,   5'd17, 5'd31, 5'd1,  12'h000, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_SRA,   5'd18, 5'd3,  5'd1,  12'h000, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_OR,    5'd19, 5'd1,  5'd2,  12'h000, 1'b0, 32'h0000_0000},
        '{rvalu_pkg::CMD_AND,   5'd20, 5'd31, 5'd2,  12'h000, 1'b0, 32'h0000_0000},
        '{CMD_FIRST_UNKNOWN, 5'd21, 5'd1, 5'd2, 12'h000, 1'b1, 32'h0000_0000},
        '{CMD_TOP_CODE, 5'd31, 5'd31, 5'd31, 12'hFFF, 1'b1, 32'h0000_0000},
        '{rvalu_pkg::CMD_ADD,   5'd0,  5'd31, 5'd31, 12'h000, 1'b1, 32'h0000_0000}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;

    logic [rvalu_pkg::XLEN-1:0] arch_regs [32];
    t_reg_write pending_writes [$];
    logic [rvalu_pkg::IDXW-1:0] latest_dest;
    int send_gap_pct;
    int recv_gap_pct;
    int hold_requests;
    int mismatches;
    int cycle_count;

    rv32i_integer_alu_execute_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [31:0] pack_instruction(
            input logic [rvalu_pkg::CMDW-1:0] cmd,
            input logic [rvalu_pkg::IDXW-1:0] rd, rs1, rs2,
            input logic [rvalu_pkg::IMMW-1:0] imm);
        return {imm, rs2, rs1, rd, cmd};
    endfunction

    // Executes one instruction against the shadow register file and returns
    // the value that the block should report for it.
    function automatic logic [rvalu_pkg::XLEN-1:0] execute_alu(
            input logic [rvalu_pkg::CMDW-1:0] cmd,
            input logic [rvalu_pkg::IDXW-1:0] rd, rs1, rs2,
            input logic [rvalu_pkg::IMMW-1:0] imm12);
        logic [rvalu_pkg::XLEN-1:0] a;
        logic [rvalu_pkg::XLEN-1:0] b;
        logic [rvalu_pkg::XLEN-1:0] imm;
        logic [rvalu_pkg::XLEN-1:0] r;
        logic                       known;
        a = (rs1 == '0) ? '0 : arch_regs[rs1];
        b = (rs2 == '0) ? '0 : arch_regs[rs2];
        imm = {{(rvalu_pkg::XLEN-rvalu_pkg::IMMW){imm12[rvalu_pkg::IMMW-1]}}, imm12};
        r = '0;
        known = 1'b1;
        case (cmd)
            rvalu_pkg::CMD_ADDI:  r = a + imm;
            rvalu_pkg::CMD_SLTI:  r = {31'd0, $signed(a) < $signed(imm)};
            rvalu_pkg::CMD_SLTIU: r = {31'd0, a < imm};
            rvalu_pkg::CMD_XORI:  r = a ^ imm;
            rvalu_pkg::CMD_ORI:   r = a | imm;
            rvalu_pkg::CMD_ANDI:  r = a & imm;
            rvalu_pkg::CMD_SLLI:  r = a << imm[4:0];
            rvalu_pkg::CMD_SRLI:  r = a >> imm[4:0];
            rvalu_pkg::CMD_SRAI:  r = $unsigned($signed(a) >>> imm[4:0]);
            rvalu_pkg::CMD_ADD:   r = a + b;
            rvalu_pkg::CMD_SUB:   r = a - b;
            rvalu_pkg::CMD_SLL:   r = a << b[4:0];
            rvalu_pkg::CMD_SLT:   r = {31'd0, $signed(a) < $signed(b)};
            rvalu_pkg::CMD_SLTU:  r = {31'd0, a < b};
            rvalu_pkg::CMD_XOR:   r = a ^ b;
            rvalu_pkg::CMD_SRL:   r = a >> b[4:0];
            rvalu_pkg::CMD_SRA:   r = $unsigned($signed(a) >>> b[4:0]);
            rvalu_pkg::CMD_OR:    r = a | b;
            rvalu_pkg::CMD_AND:   r = a & b;
            default:              known = 1'b0;
        endcase
        if (!known || rd == '0) begin
            r = '0;
        end else begin
            arch_regs[rd] = r;
        end
        return r;
    endfunction

    // Sources lean on the last destination so that back-to-back items often hit the
    // write-back forwarding path.
    function automatic logic [31:0] random_instruction();
        logic [rvalu_pkg::CMDW-1:0] cmd;
        logic [rvalu_pkg::IDXW-1:0] rd;
        logic [rvalu_pkg::IDXW-1:0] rs1;
        logic [rvalu_pkg::IDXW-1:0] rs2;
        logic [rvalu_pkg::IMMW-1:0] imm;
        int pick;
        if ($urandom_range(99) < 8) begin
            cmd = CMD_FIRST_UNKNOWN
                + rvalu_pkg::CMDW'($urandom_range(CMD_TOP_CODE - CMD_FIRST_UNKNOWN));
        end else begin
            cmd = rvalu_pkg::CMDW'($urandom_range(rvalu_pkg::CMD_AND));
        end
        rd = rvalu_pkg::IDXW'($urandom_range(31));
        rs1 = ($urandom_range(99) < 35) ? latest_dest : rvalu_pkg::IDXW'($urandom_range(31));
        rs2 = ($urandom_range(99) < 25) ? latest_dest : rvalu_pkg::IDXW'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 20) begin
            imm = rvalu_pkg::IMMW'($urandom_range(63));
        end else if (pick < 35) begin
            case ($urandom_range(3))
                0: imm = 12'h7FF;
                1: imm = 12'h800;
                2: imm = 12'hFFF;
                default: imm = 12'h000;
            endcase
        end else begin
            imm = rvalu_pkg::IMMW'($urandom_range(4095));
        end
        return pack_instruction(cmd, rd, rs1, rs2, imm);
    endfunction

    // Offers one item and returns at the edge where it is taken. Valid stays
    // high between back-to-back items and only drops for a gap.
    task automatic offer_item(input logic [31:0] word);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic commit_instruction(input logic [31:0] word, input logic fixed,
                                      input logic [rvalu_pkg::XLEN-1:0] want);
        t_reg_write entry;
        logic [rvalu_pkg::XLEN-1:0] val;
        val = execute_alu(word[4:0], word[9:5], word[14:10], word[19:15], word[31:20]);
        entry.idx = word[9:5];
        entry.val = fixed ? want : val;
        pending_writes.push_back(entry);
        latest_dest = word[9:5];
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random back-pressure, plus a long hold whenever one is requested.
    initial begin : receiver
        int served;
        int hold_left;
        served = 0;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests > served) begin
                served = served + 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_reg_write got;
        t_reg_write want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.idx = o_m_axis_tdata[4:0];
            got.val = o_m_axis_tdata[36:5];
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual idx %0d value %h",
                         $time, got.idx, got.val);
                mismatches = mismatches + 1;
            end else begin
                want = pending_writes.pop_front();
                if (got.idx !== want.idx) begin
                    $display("%0t: written_index expected %0d actual %0d",
                             $time, want.idx, got.idx);
                    mismatches = mismatches + 1;
                end
                if (got.val !== want.val) begin
                    $display("%0t: written_value (x%0d) expected %h actual %h",
                             $time, want.idx, want.val, got.val);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row row;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_requests = 0;
        mismatches = 0;
        cycle_count = 0;
        latest_dest = '0;
        for (int i = 0; i < 32; i++) arch_regs[i] = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 11;
        recv_gap_pct = 73;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            offer_item(pack_instruction(row.cmd, row.rd, row.rs1, row.rs2, row.imm));
            commit_instruction(pack_instruction(row.cmd, row.rd, row.rs1, row.rs2, row.imm),
                               row.fixed, row.want);
        end
        pause_until_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 11;
                    recv_gap_pct = 73;
                end
                1: begin
                    send_gap_pct = 73;
                    recv_gap_pct = 11;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                    // Stall the output while items keep coming so that the
                    // whole path fills and the input stalls too.
                    hold_requests = hold_requests + 1;
                end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                logic [31:0] word;
                word = random_instruction();
                offer_item(word);
                commit_instruction(word, 1'b0, '0);
            end
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
